@@ rtl/lpp_pkg.sv @@
// Shared types and constants for the LL(1) predictive parse engine.
// Used by lpp_ctrl, lpp_datapath and the top level; depends on nothing.
`default_nettype none
package lpp_pkg;

   localparam int SYM_W      = 7;
   localparam int TERM_W     = 6;
   localparam int PROD_W     = 6;
   localparam int POS_W      = 3;
   localparam int LEN_W      = 4;
   localparam int SP_W       = 7;
   localparam int STK_AW     = 6;
   localparam int EXP_W      = 6;
   localparam int TBL_AW     = SYM_W + TERM_W;
   localparam int RHS_AW     = PROD_W + POS_W;
   localparam int TBL_DEPTH  = 1 << TBL_AW;
   localparam int RHS_DEPTH  = 1 << RHS_AW;
   localparam int PROD_DEPTH = 1 << PROD_W;
   localparam int STK_DEPTH  = 1 << STK_AW;

   localparam logic [LEN_W-1:0] MAX_RHS        = 4'd8;
   localparam logic [SP_W-1:0]  STACK_DEPTH    = 7'd64;
   localparam logic [EXP_W-1:0] MAX_EXPANSIONS = 6'd32;

   localparam logic [2:0] CMD_TABLE = 3'd0;
   localparam logic [2:0] CMD_RHS   = 3'd1;
   localparam logic [2:0] CMD_LEN   = 3'd2;
   localparam logic [2:0] CMD_START = 3'd3;
   localparam logic [2:0] CMD_TOKEN = 3'd4;

   localparam logic [1:0] KIND_PROD   = 2'd0;
   localparam logic [1:0] KIND_MATCH  = 2'd1;
   localparam logic [1:0] KIND_ACCEPT = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_ACC  = 2'd2;
   localparam logic [1:0] ST_REJ  = 2'd3;

   localparam logic CSR_TERM_COUNT = 1'b0;
   localparam logic CSR_START_SYM  = 1'b1;

   typedef struct packed {
      logic       capture;
      logic       clr_step;
      logic       tbl_we;
      logic       rhs_we;
      logic       len_we;
      logic       start0;
      logic       start1;
      logic       pop;
      logic       tbl_rd;
      logic       len_rd;
      logic       j_load;
      logic       rhs_rd;
      logic       push;
      logic       j_dec;
      logic       exp_clr;
      logic       exp_inc;
      logic       emit;
      logic [1:0] emit_kind;
      logic       emit_prod;
      logic       emit_last;
      logic       set_stat;
      logic [1:0] stat_val;
   } lpp_cmd_type;

   typedef struct packed {
      logic       clr_done;
      logic [2:0] cmd;
      logic       run;
      logic       sp_zero;
      logic       sp_full;
      logic       top_end;
      logic       top_term;
      logic       top_match;
      logic       tok_zero;
      logic       ent_valid;
      logic       exp_full;
      logic       len_zero;
      logic       j_one;
      logic       sym_eps;
      logic       out_free;
   } lpp_status_type;

endpackage
`default_nettype wire

@@ rtl/lpp_datapath.sv @@
// Datapath of the parse engine: item register, parse table, rhs stores,
// parse stack, counters and the result register. Uses lpp_pkg.
`default_nettype none
module lpp_datapath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lpp_pkg::lpp_cmd_type     cmd,
   output lpp_pkg::lpp_status_type       status,
   input  wire logic [39:0]              req_tdata,
   input  wire logic [2:0]               req_tuser,
   input  wire logic [5:0]               term_count,
   input  wire logic [6:0]               start_symbol,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [7:0]                    rsp_tdata,
   output logic [1:0]                    rsp_tuser,
   output logic                          rsp_tlast
);

   // captured item
   logic [2:0]                     cmd_ff;
   logic [lpp_pkg::SYM_W-1:0]      row_ff;
   logic [lpp_pkg::TERM_W-1:0]     col_ff;
   logic                           valid_ff;
   logic [lpp_pkg::PROD_W-1:0]     prod_ff;
   logic [lpp_pkg::POS_W-1:0]      pos_ff;
   logic [lpp_pkg::SYM_W-1:0]      sym_ff;
   logic [lpp_pkg::LEN_W-1:0]      len_ff;
   logic [lpp_pkg::TERM_W-1:0]     tok_ff;

   logic [lpp_pkg::SYM_W:0]        tbl_mem [lpp_pkg::TBL_DEPTH];
   logic [lpp_pkg::SYM_W-1:0]      rhs_mem [lpp_pkg::RHS_DEPTH];
   logic [lpp_pkg::LEN_W-1:0]      len_mem [lpp_pkg::PROD_DEPTH];
   logic [lpp_pkg::SYM_W-1:0]      stk_mem [lpp_pkg::STK_DEPTH];

   logic [lpp_pkg::SYM_W:0]        tbl_q;
   logic [lpp_pkg::LEN_W-1:0]      len_q;
   logic [lpp_pkg::SYM_W-1:0]      rhs_q;
   logic [lpp_pkg::SYM_W-1:0]      stk_q;

   logic [lpp_pkg::TBL_AW-1:0]     clr_ff;
   logic                           clr_done_ff;
   logic [lpp_pkg::SP_W-1:0]       sp_ff;
   logic [lpp_pkg::SP_W-1:0]       sp_in;
   logic [1:0]                     stat_ff;
   logic [lpp_pkg::EXP_W-1:0]      exp_ff;
   logic [lpp_pkg::LEN_W-1:0]      j_ff;
   logic [lpp_pkg::PROD_W-1:0]     p_ff;

   logic                           rsp_valid_ff;
   logic [1:0]                     rsp_kind_ff;
   logic [lpp_pkg::PROD_W-1:0]     rsp_prod_ff;
   logic                           rsp_last_ff;

   logic                           tbl_wen;
   logic [lpp_pkg::TBL_AW-1:0]     tbl_waddr;
   logic [lpp_pkg::SYM_W:0]        tbl_wdata;
   logic [lpp_pkg::LEN_W-1:0]      len_sat;
   logic [lpp_pkg::LEN_W-1:0]      rd_pos_w;
   logic [lpp_pkg::SP_W-1:0]       sp_dec;
   logic                           stk_wen;
   logic [lpp_pkg::STK_AW-1:0]     stk_waddr;
   logic [lpp_pkg::SYM_W-1:0]      stk_wdata;
   logic                           out_free;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff   <= req_tuser;
         row_ff   <= req_tdata[6:0];
         col_ff   <= req_tdata[12:7];
         valid_ff <= req_tdata[13];
         prod_ff  <= req_tdata[19:14];
         pos_ff   <= req_tdata[22:20];
         sym_ff   <= req_tdata[29:23];
         len_ff   <= req_tdata[33:30];
         tok_ff   <= req_tdata[39:34];
      end
   end

   // parse table: clearing pass after reset shares the single write port
   assign tbl_wen   = cmd.clr_step | cmd.tbl_we;
   assign tbl_waddr = cmd.clr_step ? clr_ff : {row_ff, col_ff};
   assign tbl_wdata = (cmd.clr_step || !valid_ff) ? '0 : {1'b1, 1'b0, prod_ff};

   always_ff @(posedge clock) begin
      if (tbl_wen) begin
         tbl_mem[tbl_waddr] <= tbl_wdata;
      end
      if (cmd.tbl_rd) begin
         tbl_q <= tbl_mem[{stk_q, tok_ff}];
      end
   end

   assign len_sat  = (len_ff > lpp_pkg::MAX_RHS) ? lpp_pkg::MAX_RHS : len_ff;
   assign rd_pos_w = cmd.j_load ? (len_q - 4'd1) : (j_ff - 4'd2);

   always_ff @(posedge clock) begin
      if (cmd.len_we) begin
         len_mem[prod_ff] <= len_sat;
      end
      if (cmd.len_rd) begin
         len_q <= len_mem[tbl_q[lpp_pkg::PROD_W-1:0]];
         p_ff  <= tbl_q[lpp_pkg::PROD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rhs_we) begin
         rhs_mem[{prod_ff, pos_ff}] <= sym_ff;
      end
      if (cmd.rhs_rd) begin
         rhs_q <= rhs_mem[{p_ff, rd_pos_w[lpp_pkg::POS_W-1:0]}];
      end
   end

   // parse stack
   assign sp_dec    = sp_ff - 7'd1;
   assign stk_wen   = cmd.start0 | cmd.start1 | cmd.push;
   assign stk_waddr = cmd.start0 ? 6'd0 : (cmd.start1 ? 6'd1 : sp_ff[lpp_pkg::STK_AW-1:0]);
   assign stk_wdata = cmd.start0 ? '0 : (cmd.start1 ? start_symbol : rhs_q);

   always_ff @(posedge clock) begin
      if (stk_wen) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (cmd.pop) begin
         stk_q <= stk_mem[sp_dec[lpp_pkg::STK_AW-1:0]];
      end
   end

   always_comb begin
      sp_in = sp_ff;
      if (cmd.start1) begin
         sp_in = 7'd2;
      end else if (cmd.pop) begin
         sp_in = sp_dec;
      end else if (cmd.push) begin
         sp_in = sp_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.j_load) begin
         j_ff <= len_q;
      end else if (cmd.j_dec) begin
         j_ff <= j_ff - 4'd1;
      end
      if (cmd.exp_clr) begin
         exp_ff <= '0;
      end else if (cmd.exp_inc) begin
         exp_ff <= exp_ff + 6'd1;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         clr_done_ff  <= 1'b0;
         sp_ff        <= '0;
         stat_ff      <= lpp_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + 13'd1;
            if (clr_ff == 13'(lpp_pkg::TBL_DEPTH - 1)) begin
               clr_done_ff <= 1'b1;
            end
         end
         sp_ff <= sp_in;
         if (cmd.start1) begin
            stat_ff <= lpp_pkg::ST_RUN;
         end else if (cmd.set_stat) begin
            stat_ff <= cmd.stat_val;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff <= cmd.emit_kind;
         rsp_prod_ff <= cmd.emit_prod ? tbl_q[lpp_pkg::PROD_W-1:0] : '0;
         rsp_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_prod_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      status.clr_done  = clr_done_ff;
      status.cmd       = cmd_ff;
      status.run       = stat_ff == lpp_pkg::ST_RUN;
      status.sp_zero   = sp_ff == '0;
      status.sp_full   = sp_ff >= lpp_pkg::STACK_DEPTH;
      status.top_end   = stk_q == '0;
      status.top_term  = stk_q < {1'b0, term_count};
      status.top_match = stk_q == {1'b0, tok_ff};
      status.tok_zero  = tok_ff == '0;
      status.ent_valid = tbl_q[lpp_pkg::SYM_W];
      status.exp_full  = exp_ff >= lpp_pkg::MAX_EXPANSIONS;
      status.len_zero  = len_q == '0;
      status.j_one     = j_ff == 4'd1;
      status.sym_eps   = rhs_q == {1'b0, term_count};
      status.out_free  = out_free;
   end

   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= lpp_pkg::STACK_DEPTH) else $error("stack pointer beyond depth");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> sp_ff < lpp_pkg::STACK_DEPTH) else $error("push onto full stack");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free) else $error("result overwritten before taken");
   a_no_use_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> clr_done_ff) else $error("item taken during table clear");

endmodule
`default_nettype wire

@@ rtl/lpp_ctrl.sv @@
// Sequencer of the parse engine: decodes items and steps pop, lookup,
// expand and push through the datapath. Uses lpp_pkg.
`default_nettype none
module lpp_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire lpp_pkg::lpp_status_type  status,
   output lpp_pkg::lpp_cmd_type          cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_START2, S_POP, S_TOP, S_LOOK, S_LEN, S_PUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            if (status.clr_done) begin
               state_in = S_IDLE;
            end else begin
               cmd.clr_step = 1'b1;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.cmd)
               lpp_pkg::CMD_TABLE: begin
                  cmd.tbl_we = 1'b1;
                  state_in   = S_IDLE;
               end
               lpp_pkg::CMD_RHS: begin
                  cmd.rhs_we = 1'b1;
                  state_in   = S_IDLE;
               end
               lpp_pkg::CMD_LEN: begin
                  cmd.len_we = 1'b1;
                  state_in   = S_IDLE;
               end
               lpp_pkg::CMD_START: begin
                  cmd.start0 = 1'b1;
                  state_in   = S_START2;
               end
               lpp_pkg::CMD_TOKEN: begin
                  if (status.run) begin
                     cmd.exp_clr = 1'b1;
                     state_in    = S_POP;
                  end else if (status.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = lpp_pkg::KIND_REJECT;
                     cmd.emit_last = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_START2: begin
            cmd.start1 = 1'b1;
            state_in   = S_IDLE;
         end
         S_POP: begin
            if (!status.sp_zero) begin
               cmd.pop  = 1'b1;
               state_in = S_TOP;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = lpp_pkg::KIND_REJECT;
               cmd.emit_last = 1'b1;
               cmd.set_stat  = 1'b1;
               cmd.stat_val  = lpp_pkg::ST_REJ;
               state_in      = S_IDLE;
            end
         end
         S_TOP: begin
            if (status.top_end) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_last = 1'b1;
                  cmd.set_stat  = 1'b1;
                  cmd.emit_kind = status.tok_zero ? lpp_pkg::KIND_ACCEPT
                                                  : lpp_pkg::KIND_REJECT;
                  cmd.stat_val  = status.tok_zero ? lpp_pkg::ST_ACC : lpp_pkg::ST_REJ;
                  state_in      = S_IDLE;
               end
            end else if (status.top_term) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_last = 1'b1;
                  if (status.top_match) begin
                     cmd.emit_kind = lpp_pkg::KIND_MATCH;
                  end else begin
                     cmd.emit_kind = lpp_pkg::KIND_REJECT;
                     cmd.set_stat  = 1'b1;
                     cmd.stat_val  = lpp_pkg::ST_REJ;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               cmd.tbl_rd = 1'b1;
               state_in   = S_LOOK;
            end
         end
         S_LOOK: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (!status.ent_valid || status.exp_full) begin
                  cmd.emit_kind = lpp_pkg::KIND_REJECT;
                  cmd.emit_last = 1'b1;
                  cmd.set_stat  = 1'b1;
                  cmd.stat_val  = lpp_pkg::ST_REJ;
                  state_in      = S_IDLE;
               end else begin
                  cmd.emit_kind = lpp_pkg::KIND_PROD;
                  cmd.emit_prod = 1'b1;
                  cmd.exp_inc   = 1'b1;
                  cmd.len_rd    = 1'b1;
                  state_in      = S_LEN;
               end
            end
         end
         S_LEN: begin
            if (status.len_zero) begin
               state_in = S_POP;
            end else begin
               cmd.j_load = 1'b1;
               cmd.rhs_rd = 1'b1;
               state_in   = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!status.sym_eps && status.sp_full) begin
               if (status.out_free) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = lpp_pkg::KIND_REJECT;
                  cmd.emit_last = 1'b1;
                  cmd.set_stat  = 1'b1;
                  cmd.stat_val  = lpp_pkg::ST_REJ;
                  state_in      = S_IDLE;
               end
            end else begin
               // epsilon symbols are dropped, everything else goes on the stack
               cmd.push  = !status.sym_eps;
               cmd.j_dec = 1'b1;
               if (status.j_one) begin
                  state_in = S_POP;
               end else begin
                  cmd.rhs_rd = 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE) else $error("ready outside idle");
   a_clear_first: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_step |-> !req_tready) else $error("ready during table clear");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push, cmd.start0, cmd.start1})) else $error("stack write clash");

endmodule
`default_nettype wire

@@ rtl/ll1_predictive_parse_engine_unit.sv @@
// Top level of the LL(1) predictive parse engine: CSR block plus the
// controller (lpp_ctrl) and datapath (lpp_datapath). Uses lpp_pkg.
//
// Usage:
//  - req channel: one transaction per command. req_tuser carries cmd; load
//    commands fill the parse table, rhs symbols and rhs lengths, start sets
//    up the stack, token runs the parse for one input terminal.
//  - rsp channel: results of a token, production applied (kind 0) per
//    expansion, then one final matched/accepted/rejected with tlast set.
//  - csr: terminal_count at 0x0, start_symbol at 0x4; write only while idle.
//  - Loads are written in S_DECODE, start in S_DECODE and S_START2. A token
//    pops, looks up and expands, then reads rhs symbols (epsilon included)
//    one symbol a cycle, pushing all but epsilon via the single stack port.
//    One command is in work at a time.
//  - After reset the 8192-entry parse table is cleared one entry a cycle
//    with req_tready low. CSR writes are taken during that pass.
//  - A stalled receiver holds the result register; the engine waits with it.
`default_nettype none
module ll1_predictive_parse_engine_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [6:0] row_symbol, [12:7] column_terminal, [13] entry_valid,
   // [19:14] production_number, [22:20] rhs_position, [29:23] rhs_symbol,
   // [33:30] rhs_length, [39:34] token
   input  wire logic [39:0] req_tdata,
   input  wire logic [2:0]  req_tuser,  // [2:0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,  // [5:0] production_used, [7:6] zero
   output logic [1:0]       rsp_tuser,  // [1:0] kind
   output logic             rsp_tlast,  // last
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [5:0]              tc_ff;
   logic [6:0]              start_ff;
   logic                    csr_wr;
   lpp_pkg::lpp_cmd_type    cmd;
   lpp_pkg::lpp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff    <= 6'd1;
         start_ff <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[2] == lpp_pkg::CSR_TERM_COUNT) begin
            tc_ff <= csr_pwdata[5:0];
         end else begin
            start_ff <= csr_pwdata[6:0];
         end
      end
   end

   always_comb begin
      case (csr_paddr[2])
         lpp_pkg::CSR_TERM_COUNT: csr_prdata = {26'd0, tc_ff};
         lpp_pkg::CSR_START_SYM:  csr_prdata = {25'd0, start_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   lpp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lpp_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .term_count   (tc_ff),
      .start_symbol (start_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule
`default_nettype wire
